// File: hw/rtl/srt_pkg.sv
// ---------------------------------------------------------------------------
// srt_pkg: shared types and constants for the sorted region table checker
// Field widths, request kinds, status codes and the table entry layout.
// ---------------------------------------------------------------------------
package srt_pkg;

  // field widths of the item and result beats
  localparam int ADDR_W   = 64;
  localparam int PERM_W   = 8;
  localparam int SLOT_W   = 4;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // default table depth
  localparam int MAX_REGIONS_DEF = 16;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RM_INDEX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RM_BASE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CHECK    = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADARG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // one table entry
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic [PERM_W-1:0] perm;
  } entry_t;

  // shared adder request: sum = a + ~b + cin
  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic              cin;
  } alu_req_t;

  // shared adder result
  typedef struct packed {
    logic [ADDR_W-1:0] sum;
    logic              carry;
    logic              zero;
  } alu_res_t;

endpackage

// File: hw/rtl/srt_if.sv
// ---------------------------------------------------------------------------
// srt_if: valid/ready channels of the region table checker
// Request channel (srt_in_if) and result channel (srt_out_if).
// ---------------------------------------------------------------------------
interface srt_in_if;
  logic                          valid;
  logic                          ready;
  logic [srt_pkg::KIND_W-1:0]    kind;
  logic [srt_pkg::ADDR_W-1:0]    address;
  logic [srt_pkg::ADDR_W-1:0]    length;
  logic [srt_pkg::PERM_W-1:0]    perm_mask;
  logic [srt_pkg::SLOT_W-1:0]    slot;

  modport source (output valid, kind, address, length, perm_mask, slot, input ready);
  modport sink   (input valid, kind, address, length, perm_mask, slot, output ready);
endinterface

interface srt_out_if;
  logic                          valid;
  logic                          ready;
  logic [srt_pkg::STATUS_W-1:0]  status;
  logic [srt_pkg::SLOT_W-1:0]    slot_out;
  logic [srt_pkg::COUNT_W-1:0]   region_count;

  modport source (output valid, status, slot_out, region_count, input ready);
  modport sink   (input valid, status, slot_out, region_count, output ready);
endinterface

// File: hw/rtl/sorted_region_table_checker_unit.sv
// ---------------------------------------------------------------------------
// sorted_region_table_checker_unit: sorted memory protection region table
// Sequencer, result register and instances of the shared adder and table.
// ---------------------------------------------------------------------------
// One request beat is taken at a time; in_bus.ready is high only while the
// sequencer is idle, and a finished result waits in the output register so
// the next request can be taken before it is drained. A request other than a
// remove by index runs a binary search for the first base not below the
// address, then inspects the entries around the search point; a check adds a
// range check, and an insert or remove moves one entry per cycle. Speed is
// bounded by the one 64-bit adder that every address compare goes through and
// by the single read and single write port of the table memory. Table
// contents need no clearing after reset.
// ---------------------------------------------------------------------------
module sorted_region_table_checker_unit #(
  parameter int MAX_REGIONS = srt_pkg::MAX_REGIONS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  srt_in_if.sink    in_bus,
  srt_out_if.source out_bus
);

  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ARG   = 5'd1;
  localparam logic [4:0] S_SRCH  = 5'd2;
  localparam logic [4:0] S_HRD   = 5'd3;
  localparam logic [4:0] S_HCMP  = 5'd4;
  localparam logic [4:0] S_HCMP2 = 5'd5;
  localparam logic [4:0] S_LRD   = 5'd6;
  localparam logic [4:0] S_LCMP  = 5'd7;
  localparam logic [4:0] S_LCMP2 = 5'd8;
  localparam logic [4:0] S_FULL  = 5'd9;
  localparam logic [4:0] S_SHUP  = 5'd10;
  localparam logic [4:0] S_PUT   = 5'd11;
  localparam logic [4:0] S_SHDN  = 5'd12;
  localparam logic [4:0] S_RMIDX = 5'd13;
  localparam logic [4:0] S_CHK1  = 5'd14;
  localparam logic [4:0] S_CHK2  = 5'd15;
  localparam logic [4:0] S_CHK3  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]                     state_r, state_nxt;
  logic [srt_pkg::KIND_W-1:0]     kind_r, kind_nxt;
  logic [srt_pkg::ADDR_W-1:0]     addr_r, addr_nxt;
  logic [srt_pkg::ADDR_W-1:0]     len_r, len_nxt;
  logic [srt_pkg::PERM_W-1:0]     perm_r, perm_nxt;
  logic [srt_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [CNT_W-1:0]               used_r, used_nxt;
  logic [CNT_W-1:0]               lo_r, lo_nxt;
  logic [CNT_W-1:0]               hi_r, hi_nxt;
  logic [CNT_W-1:0]               mid_r, mid_nxt;
  logic [CNT_W-1:0]               k_r, k_nxt;
  logic [CNT_W-1:0]               where_r, where_nxt;
  logic [srt_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [srt_pkg::ADDR_W-1:0]     diff_r, diff_nxt;
  logic [srt_pkg::ADDR_W-1:0]     tmp_r, tmp_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [srt_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [srt_pkg::SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [srt_pkg::COUNT_W-1:0]    out_count_r, out_count_nxt;

  srt_pkg::alu_req_t              alu_req;
  srt_pkg::alu_res_t              alu_res;

  logic                           mem_rd_en;
  logic [IDX_W-1:0]               mem_rd_addr;
  srt_pkg::entry_t                rd_data;
  logic                           mem_wr_en;
  logic [IDX_W-1:0]               mem_wr_addr;
  srt_pkg::entry_t                mem_wr_data;

  logic                           in_fire;
  logic                           base_lt;
  logic [CNT_W-1:0]               lo_s, hi_s, mid_s, ptr_a, ptr_b;
  logic [CNT_W+srt_pkg::SLOT_W-1:0] slot_w, used_w, where_w;
  logic [CNT_W+srt_pkg::COUNT_W-1:0] count_w;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;

  // widened copies for mixed-width compares and output masking
  assign slot_w  = {{CNT_W{1'b0}}, slot_r};
  assign used_w  = {{srt_pkg::SLOT_W{1'b0}}, used_r};
  assign where_w = {{srt_pkg::SLOT_W{1'b0}}, where_r};
  assign count_w = {{srt_pkg::COUNT_W{1'b0}}, used_r};

  // shared adder
  srt_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // region table
  srt_mem #(
    .DEPTH (MAX_REGIONS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    perm_nxt       = perm_r;
    slot_nxt       = slot_r;
    used_nxt       = used_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    k_nxt          = k_r;
    where_nxt      = where_r;
    status_nxt     = status_r;
    diff_nxt       = diff_r;
    tmp_nxt        = tmp_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;

    alu_req     = '{a: addr_r, b: ~len_r, cin: 1'b0};
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '{base: addr_r, size: len_r, perm: perm_r};

    base_lt = 1'b0;
    lo_s    = lo_r;
    hi_s    = hi_r;
    mid_s   = mid_r;
    ptr_a   = '0;
    ptr_b   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt   = in_bus.kind;
          addr_nxt   = in_bus.address;
          len_nxt    = in_bus.length;
          perm_nxt   = in_bus.perm_mask;
          slot_nxt   = in_bus.slot;
          status_nxt = srt_pkg::ST_OK;
          where_nxt  = '0;
          state_nxt  = (in_bus.kind == srt_pkg::KIND_RM_INDEX) ? S_RMIDX : S_ARG;
        end
      end

      // zero length or wrap past the top: address + length > 2^64
      S_ARG: begin
        alu_req = '{a: addr_r, b: ~len_r, cin: 1'b0};
        lo_nxt  = '0;
        hi_nxt  = used_r;
        if (kind_r != srt_pkg::KIND_RM_BASE &&
            (len_r == '0 || (alu_res.carry && !alu_res.zero))) begin
          status_nxt = (kind_r == srt_pkg::KIND_INSERT) ? srt_pkg::ST_BADARG
                                                        : srt_pkg::ST_RANGE;
          state_nxt  = S_DONE;
        end else if (used_r == '0) begin
          state_nxt = (kind_r == srt_pkg::KIND_INSERT) ? S_LRD : S_HRD;
        end else begin
          mid_nxt     = used_r >> 1;
          mem_rd_en   = 1'b1;
          mem_rd_addr = mid_nxt[IDX_W-1:0];
          state_nxt   = S_SRCH;
        end
      end

      // binary search for the first base not below address, one step a cycle
      S_SRCH: begin
        alu_req = '{a: rd_data.base, b: addr_r, cin: 1'b1};
        base_lt = !alu_res.carry;
        lo_s    = base_lt ? (mid_r + CNT_ONE) : lo_r;
        hi_s    = base_lt ? hi_r : mid_r;
        lo_nxt  = lo_s;
        hi_nxt  = hi_s;
        if (lo_s < hi_s) begin
          mid_s       = lo_s + ((hi_s - lo_s) >> 1);
          mid_nxt     = mid_s;
          mem_rd_en   = 1'b1;
          mem_rd_addr = mid_s[IDX_W-1:0];
        end else begin
          state_nxt = (kind_r == srt_pkg::KIND_INSERT) ? S_LRD : S_HRD;
        end
      end

      // fetch the entry at the search point
      S_HRD: begin
        if (lo_r < used_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = lo_r[IDX_W-1:0];
          state_nxt   = S_HCMP;
        end else if (kind_r == srt_pkg::KIND_INSERT) begin
          state_nxt = S_FULL;
        end else if (kind_r == srt_pkg::KIND_CHECK) begin
          state_nxt = S_LRD;
        end else begin
          status_nxt = srt_pkg::ST_RANGE;
          state_nxt  = S_DONE;
        end
      end

      // upper entry: base - address, exact match test
      S_HCMP: begin
        alu_req  = '{a: rd_data.base, b: addr_r, cin: 1'b1};
        diff_nxt = alu_res.sum;
        if (kind_r == srt_pkg::KIND_INSERT) begin
          state_nxt = S_HCMP2;
        end else if (kind_r == srt_pkg::KIND_RM_BASE) begin
          if (alu_res.zero) begin
            where_nxt = lo_r;
            k_nxt     = lo_r;
            ptr_a     = lo_r + CNT_ONE;
            if (ptr_a < used_r) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = ptr_a[IDX_W-1:0];
              state_nxt   = S_SHDN;
            end else begin
              used_nxt  = used_r - CNT_ONE;
              state_nxt = S_DONE;
            end
          end else begin
            status_nxt = srt_pkg::ST_RANGE;
            state_nxt  = S_DONE;
          end
        end else begin
          if (alu_res.zero) begin
            where_nxt = lo_r;
            state_nxt = S_CHK1;
          end else begin
            state_nxt = S_LRD;
          end
        end
      end

      // insert: new region must end before the upper neighbor
      S_HCMP2: begin
        alu_req = '{a: diff_r, b: len_r, cin: 1'b1};
        if (!alu_res.carry) begin
          status_nxt = srt_pkg::ST_BADARG;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_FULL;
        end
      end

      // fetch the entry below the search point
      S_LRD: begin
        if (lo_r != '0) begin
          ptr_a       = lo_r - CNT_ONE;
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_a[IDX_W-1:0];
          state_nxt   = S_LCMP;
        end else if (kind_r == srt_pkg::KIND_INSERT) begin
          state_nxt = S_HRD;
        end else begin
          status_nxt = srt_pkg::ST_RANGE;
          state_nxt  = S_DONE;
        end
      end

      // lower entry: address - base
      S_LCMP: begin
        alu_req   = '{a: addr_r, b: rd_data.base, cin: 1'b1};
        diff_nxt  = alu_res.sum;
        state_nxt = S_LCMP2;
      end

      // lower entry contains address when the offset is below its size
      S_LCMP2: begin
        alu_req = '{a: diff_r, b: rd_data.size, cin: 1'b1};
        if (kind_r == srt_pkg::KIND_INSERT) begin
          if (!alu_res.carry) begin
            status_nxt = srt_pkg::ST_BADARG;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_HRD;
          end
        end else begin
          if (!alu_res.carry) begin
            where_nxt = lo_r - CNT_ONE;
            state_nxt = S_CHK1;
          end else begin
            status_nxt = srt_pkg::ST_RANGE;
            state_nxt  = S_DONE;
          end
        end
      end

      // full table test, then open a gap at the insert point
      S_FULL: begin
        if (used_r >= CNT_MAX) begin
          status_nxt = srt_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          k_nxt = used_r;
          if (used_r > lo_r) begin
            ptr_a       = used_r - CNT_ONE;
            mem_rd_en   = 1'b1;
            mem_rd_addr = ptr_a[IDX_W-1:0];
            state_nxt   = S_SHUP;
          end else begin
            state_nxt = S_PUT;
          end
        end
      end

      // move entry k-1 to k, reading k-2 in the same cycle
      S_SHUP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = k_r[IDX_W-1:0];
        mem_wr_data = rd_data;
        ptr_a       = k_r - CNT_ONE;
        k_nxt       = ptr_a;
        if (ptr_a > lo_r) begin
          ptr_b       = ptr_a - CNT_ONE;
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_b[IDX_W-1:0];
        end else begin
          state_nxt = S_PUT;
        end
      end

      // write the new region into the gap
      S_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = lo_r[IDX_W-1:0];
        used_nxt    = used_r + CNT_ONE;
        where_nxt   = lo_r;
        state_nxt   = S_DONE;
      end

      // move entry k+1 to k, reading k+2 in the same cycle
      S_SHDN: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = k_r[IDX_W-1:0];
        mem_wr_data = rd_data;
        ptr_a       = k_r + CNT_ONE;
        ptr_b       = used_r - CNT_ONE;
        k_nxt       = ptr_a;
        if (ptr_a < ptr_b) begin
          ptr_b       = ptr_a + CNT_ONE;
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_b[IDX_W-1:0];
        end else begin
          used_nxt  = used_r - CNT_ONE;
          state_nxt = S_DONE;
        end
      end

      // remove by index
      S_RMIDX: begin
        if (slot_w >= used_w) begin
          status_nxt = srt_pkg::ST_BADARG;
          state_nxt  = S_DONE;
        end else begin
          where_nxt = slot_w[CNT_W-1:0];
          k_nxt     = slot_w[CNT_W-1:0];
          ptr_a     = slot_w[CNT_W-1:0] + CNT_ONE;
          if (ptr_a < used_r) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ptr_a[IDX_W-1:0];
            state_nxt   = S_SHDN;
          end else begin
            used_nxt  = used_r - CNT_ONE;
            state_nxt = S_DONE;
          end
        end
      end

      // check: permissions present and length fits, keep size - length
      S_CHK1: begin
        alu_req = '{a: rd_data.size, b: len_r, cin: 1'b1};
        tmp_nxt = alu_res.sum;
        if (!alu_res.carry || ((rd_data.perm & perm_r) != perm_r)) begin
          status_nxt = srt_pkg::ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_CHK2;
        end
      end

      // check: offset of address in the region
      S_CHK2: begin
        alu_req   = '{a: addr_r, b: rd_data.base, cin: 1'b1};
        diff_nxt  = alu_res.sum;
        state_nxt = S_CHK3;
      end

      // check: offset must not exceed size - length
      S_CHK3: begin
        alu_req = '{a: tmp_r, b: diff_r, cin: 1'b1};
        if (!alu_res.carry) begin
          status_nxt = srt_pkg::ST_RANGE;
        end
        state_nxt = S_DONE;
      end

      // post the result beat once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_slot_nxt   = (status_r == srt_pkg::ST_OK) ? where_w[srt_pkg::SLOT_W-1:0]
                                                        : '0;
          out_count_nxt  = count_w[srt_pkg::COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    addr_r       <= addr_nxt;
    len_r        <= len_nxt;
    perm_r       <= perm_nxt;
    slot_r       <= slot_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    k_r          <= k_nxt;
    where_r      <= where_nxt;
    status_r     <= status_nxt;
    diff_r       <= diff_nxt;
    tmp_r        <= tmp_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.slot_out     = out_slot_r;
  assign out_bus.region_count = out_count_r;

  // a taken request beat closes the input until the sequencer is idle again
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_bus.ready)
    else $error("input ready while a request is in progress");

  // table writes stay inside the occupied part plus the insert gap
  a_write_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (CNT_W'(mem_wr_addr) <= used_r))
    else $error("table write beyond occupied entries");

  // shifting never reads the entry it writes in the same cycle
  a_no_rw_collision : assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("table read and write at the same entry");

  // the region count only moves while a request is being worked on
  a_count_busy : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (used_r != $past(used_r))) |-> ($past(state_r) != S_IDLE))
    else $error("region count changed while idle");

  // a result beat appears only from the posting state
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result beat raised outside the posting state");

endmodule

// File: hw/rtl/srt_alu.sv
// ---------------------------------------------------------------------------
// srt_alu: shared 64-bit add/compare unit
// Computes a + ~b + cin with carry out and zero flag. With cin set this is
// a - b (carry means a >= b); with b inverted and cin clear it is a + b.
// ---------------------------------------------------------------------------
module srt_alu (
  input  srt_pkg::alu_req_t req,
  output srt_pkg::alu_res_t res
);

  logic [srt_pkg::ADDR_W:0] total;

  assign total = {1'b0, req.a} + {1'b0, ~req.b} + {{srt_pkg::ADDR_W{1'b0}}, req.cin};

  assign res.sum   = total[srt_pkg::ADDR_W-1:0];
  assign res.carry = total[srt_pkg::ADDR_W];
  assign res.zero  = (total[srt_pkg::ADDR_W-1:0] == '0);

endmodule

// File: hw/rtl/srt_mem.sv
// ---------------------------------------------------------------------------
// srt_mem: region table storage
// One write port, one read port with registered read data. The read data
// holds its value in cycles without a read.
// ---------------------------------------------------------------------------
module srt_mem #(
  parameter int DEPTH = srt_pkg::MAX_REGIONS_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output srt_pkg::entry_t      rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  srt_pkg::entry_t      wr_data
);

  srt_pkg::entry_t mem_r [DEPTH];
  srt_pkg::entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted region table checker
// Drives insert, remove-by-index, remove-by-base and range check requests
// through the valid/ready request channel, mirrors the region table in a
// local model and compares every result beat, field by field, in order.
// A short directed list opens the run; a long random phase follows, with
// random gaps on both channels and one long result-side hold-off.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES  = 50;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned HOLD_AFTER   = 60;

  localparam logic [ADDR_W-1:0] ADDR_MAX  = '1;
  localparam logic [ADDR_W-1:0] LOW_ZONE  = 64'h0000_0000_0001_0000;
  localparam logic [ADDR_W-1:0] TOP_ZONE  = 64'hFFFF_FFFF_FFFF_F000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic [PERM_W-1:0] perm_mask;
    logic [SLOT_W-1:0] slot;
  } region_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [COUNT_W-1:0]  region_count;
  } region_resp_t;

  typedef struct {
    region_req_t  req;
    bit           pinned;
    region_resp_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  srt_in_if  in_ch ();
  srt_out_if out_ch ();

  sorted_region_table_checker_unit #(
    .MAX_REGIONS(MAX_REGIONS_DEF)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // local mirror of the region table
  logic [ADDR_W-1:0] mdl_base [MAX_REGIONS_DEF];
  logic [ADDR_W-1:0] mdl_size [MAX_REGIONS_DEF];
  logic [PERM_W-1:0] mdl_perm [MAX_REGIONS_DEF];
  int unsigned       mdl_used = 0;

  region_resp_t expected_replies [$];
  plan_row_t    plan [$];
  int unsigned  fault_cnt    = 0;
  int unsigned  results_seen = 0;
  int unsigned  idle_cycles  = 0;
  int unsigned  cycle_cnt    = 0;
  bit           calm_spell   = 1'b0;
  bit           filling      = 1'b1;
  bit           pin_on       = 1'b0;
  region_resp_t pin_resp     = '0;

  // first table index whose base is not below the address
  function automatic int unsigned lower_slot(logic [ADDR_W-1:0] a);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = mdl_used;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (mdl_base[mid] < a) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // index of the region holding the address, mdl_used when none does
  function automatic int unsigned holder_slot(logic [ADDR_W-1:0] a);
    int unsigned i;
    i = lower_slot(a);
    if (i < mdl_used && mdl_base[i] == a) return i;
    if (i == 0) return mdl_used;
    i--;
    if (a - mdl_base[i] < mdl_size[i]) return i;
    return mdl_used;
  endfunction

  function automatic void drop_region(int unsigned at);
    int unsigned k;
    for (k = at; k + 1 < mdl_used; k++) begin
      mdl_base[k] = mdl_base[k+1];
      mdl_size[k] = mdl_size[k+1];
      mdl_perm[k] = mdl_perm[k+1];
    end
    mdl_used--;
  endfunction

  // apply one request to the mirror and return the result it must give
  function automatic region_resp_t predict_region_op(region_req_t q);
    region_resp_t      rsp;
    int unsigned       i, k;
    logic [STATUS_W-1:0] st;
    st = ST_OK;
    i  = 0;
    case (q.kind)
      KIND_INSERT: begin
        i = lower_slot(q.address);
        if (q.length == '0 || q.address > ADDR_MAX - (q.length - 64'd1)) st = ST_BADARG;
        else if (i != 0 && q.address - mdl_base[i-1] < mdl_size[i-1]) st = ST_BADARG;
        else if (i < mdl_used && mdl_base[i] - q.address < q.length) st = ST_BADARG;
        else if (mdl_used >= MAX_REGIONS_DEF) st = ST_FULL;
        else begin
          for (k = mdl_used; k > i; k--) begin
            mdl_base[k] = mdl_base[k-1];
            mdl_size[k] = mdl_size[k-1];
            mdl_perm[k] = mdl_perm[k-1];
          end
          mdl_base[i] = q.address;
          mdl_size[i] = q.length;
          mdl_perm[i] = q.perm_mask;
          mdl_used++;
        end
      end
      KIND_RM_INDEX: begin
        if (q.slot >= mdl_used) st = ST_BADARG;
        else begin
          i = q.slot;
          drop_region(i);
        end
      end
      KIND_RM_BASE: begin
        i = lower_slot(q.address);
        if (i < mdl_used && mdl_base[i] == q.address) drop_region(i);
        else st = ST_RANGE;
      end
      default: begin
        if (q.length == '0 || q.address > ADDR_MAX - (q.length - 64'd1)) st = ST_RANGE;
        else begin
          i = holder_slot(q.address);
          if (i >= mdl_used) st = ST_RANGE;
          else if ((mdl_perm[i] & q.perm_mask) != q.perm_mask) st = ST_RANGE;
          else if (q.length > mdl_size[i]) st = ST_RANGE;
          else if (q.address - mdl_base[i] > mdl_size[i] - q.length) st = ST_RANGE;
        end
      end
    endcase
    rsp.status       = st;
    rsp.slot_out     = (st == ST_OK) ? i[SLOT_W-1:0] : '0;
    rsp.region_count = mdl_used[COUNT_W-1:0];
    return rsp;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random request shaped by the mirror: fill the table, then drain it
  function automatic region_req_t roll_request();
    region_req_t q;
    int unsigned pick, i;
    logic [ADDR_W-1:0] off, span;
    q.kind      = KIND_CHECK;
    q.address   = rand_word64();
    q.length    = rand_word64();
    q.perm_mask = PERM_W'($urandom);
    q.slot      = SLOT_W'($urandom);
    if (mdl_used == MAX_REGIONS_DEF && $urandom_range(0, 3) == 0) filling = 1'b0;
    else if (mdl_used == 0) filling = 1'b1;
    // a few beats of pure noise
    if ($urandom_range(0, 99) < 5) begin
      q.kind = KIND_W'($urandom);
      return q;
    end
    pick = $urandom_range(0, 99);
    if (pick < (filling ? 50 : 15)) q.kind = KIND_INSERT;
    else if (pick < (filling ? 80 : 45)) q.kind = KIND_CHECK;
    else if (pick < (filling ? 90 : 75)) q.kind = KIND_RM_BASE;
    else q.kind = KIND_RM_INDEX;
    i = (mdl_used != 0) ? $urandom_range(0, mdl_used - 1) : 0;
    case (q.kind)
      KIND_INSERT: begin
        // the top zone is close enough to the end of memory to wrap often
        if ($urandom_range(0, 9) == 0) q.address = TOP_ZONE + $urandom_range(3840, 4095);
        else q.address = LOW_ZONE + $urandom_range(0, 4095);
        q.length = ($urandom_range(0, 19) == 0) ? rand_word64() : $urandom_range(1, 64);
      end
      KIND_CHECK: begin
        if (mdl_used != 0 && $urandom_range(0, 9) < 8) begin
          off       = rand_word64() % mdl_size[i];
          span      = mdl_size[i] - off;
          q.address = mdl_base[i] + off;
          q.length  = 64'd1 + rand_word64() % span;
          if ($urandom_range(0, 9) == 0) q.length = span + 64'd1;
          if ($urandom_range(0, 9) != 0) q.perm_mask = mdl_perm[i] & PERM_W'($urandom);
        end else begin
          q.address = LOW_ZONE + $urandom_range(0, 4095);
          q.length  = $urandom_range(0, 64);
        end
      end
      KIND_RM_BASE: begin
        if (mdl_used != 0 && $urandom_range(0, 3) != 0) q.address = mdl_base[i];
        else if (mdl_used != 0) q.address = mdl_base[i] + 64'd1;
        else q.address = LOW_ZONE + $urandom_range(0, 4095);
      end
      default: begin
        if (mdl_used != 0 && $urandom_range(0, 3) != 0) q.slot = i[SLOT_W-1:0];
      end
    endcase
    return q;
  endfunction

  task automatic add_row(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                         input logic [ADDR_W-1:0] l, input logic [PERM_W-1:0] p,
                         input logic [SLOT_W-1:0] s, input bit pin,
                         input logic [STATUS_W-1:0] st, input logic [SLOT_W-1:0] so,
                         input logic [COUNT_W-1:0] cnt);
    plan_row_t row;
    row.req    = {k, a, l, p, s};
    row.pinned = pin;
    row.want   = {st, so, cnt};
    plan.push_back(row);
  endtask

  // present one request beat after an optional gap, hold until accepted
  task automatic push_req(input region_req_t q, input bit pin, input region_resp_t want,
                          input int unsigned gap);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pin_on          = pin;
    pin_resp        = want;
    in_ch.kind      = q.kind;
    in_ch.address   = q.address;
    in_ch.length    = q.length;
    in_ch.perm_mask = q.perm_mask;
    in_ch.slot      = q.slot;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // calm spells: a quarter of the run, in repeating spells, runs with no idling
  always @(posedge clk) begin
    cycle_cnt  <= cycle_cnt + 1;
    calm_spell <= ((cycle_cnt % 1000) >= 750);
  end

  // request side: directed list, then random traffic, then drain
  initial begin
    region_req_t q;
    int unsigned n;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_INSERT;
    in_ch.address   = '0;
    in_ch.length    = '0;
    in_ch.perm_mask = '0;
    in_ch.slot      = '0;

    // empty table: every lookup and removal fails
    add_row(KIND_CHECK,    64'h0,    64'd1,    8'h00, 4'd0,  1, ST_RANGE,  4'd0, 5'd0);
    add_row(KIND_RM_INDEX, 64'h0,    64'd0,    8'h00, 4'd0,  1, ST_BADARG, 4'd0, 5'd0);
    add_row(KIND_RM_BASE,  64'h0,    64'd0,    8'h00, 4'd0,  1, ST_RANGE,  4'd0, 5'd0);
    // zero size, then a region that wraps past the top
    add_row(KIND_INSERT,   64'h1000, 64'd0,    8'h03, 4'd0,  1, ST_BADARG, 4'd0, 5'd0);
    add_row(KIND_INSERT,   ADDR_MAX, 64'd2,    8'hFF, 4'd0,  1, ST_BADARG, 4'd0, 5'd0);
    // last byte alone, then everything below it: the whole space is taken
    add_row(KIND_INSERT,   ADDR_MAX, 64'd1,    8'hFF, 4'd0,  1, ST_OK,     4'd0, 5'd1);
    add_row(KIND_INSERT,   64'h0,    ADDR_MAX, 8'hFF, 4'd0,  1, ST_OK,     4'd0, 5'd2);
    add_row(KIND_CHECK,    64'h0,    ADDR_MAX, 8'hFF, 4'd0,  1, ST_OK,     4'd0, 5'd2);
    add_row(KIND_CHECK,    ADDR_MAX, 64'd1,    8'h01, 4'd0,  1, ST_OK,     4'd1, 5'd2);
    // check wrapping past the top, zero-length check
    add_row(KIND_CHECK,    ADDR_MAX, 64'd2,    8'h00, 4'd0,  1, ST_RANGE,  4'd0, 5'd2);
    add_row(KIND_CHECK,    64'h40,   64'd0,    8'h00, 4'd0,  1, ST_RANGE,  4'd0, 5'd2);
    // overlap with the lower neighbor; remove by an inner address
    add_row(KIND_INSERT,   64'h5,    64'd1,    8'h01, 4'd0,  1, ST_BADARG, 4'd0, 5'd2);
    add_row(KIND_RM_BASE,  64'h5,    64'd0,    8'h00, 4'd0,  1, ST_RANGE,  4'd0, 5'd2);
    add_row(KIND_RM_INDEX, 64'h0,    64'd0,    8'h00, 4'd15, 1, ST_BADARG, 4'd0, 5'd2);
    add_row(KIND_RM_INDEX, 64'h0,    64'd0,    8'h00, 4'd0,  1, ST_OK,     4'd0, 5'd1);
    add_row(KIND_RM_BASE,  ADDR_MAX, 64'd0,    8'h00, 4'd0,  1, ST_OK,     4'd0, 5'd0);
    // overlap with the upper neighbor, then an exact fit below it
    add_row(KIND_INSERT,   64'h100,  64'h100,  8'h01, 4'd0,  1, ST_OK,     4'd0, 5'd1);
    add_row(KIND_INSERT,   64'h80,   64'h81,   8'h02, 4'd0,  1, ST_BADARG, 4'd0, 5'd1);
    add_row(KIND_INSERT,   64'h80,   64'h80,   8'h02, 4'd0,  1, ST_OK,     4'd0, 5'd2);
    // range spanning two regions, missing write bit, range ending at the edge
    add_row(KIND_CHECK,    64'h80,   64'h180,  8'h00, 4'd0,  1, ST_RANGE,  4'd0, 5'd2);
    add_row(KIND_CHECK,    64'h100,  64'h10,   8'h02, 4'd0,  1, ST_RANGE,  4'd0, 5'd2);
    add_row(KIND_CHECK,    64'h1F0,  64'h10,   8'h01, 4'd0,  1, ST_OK,     4'd1, 5'd2);
    add_row(KIND_INSERT,   64'h200,  64'h40,   8'hA5, 4'd0,  0, ST_OK,     4'd0, 5'd0);
    add_row(KIND_CHECK,    64'h1FF,  64'd2,    8'h01, 4'd0,  0, ST_OK,     4'd0, 5'd0);
    add_row(KIND_RM_INDEX, 64'h0,    64'd0,    8'h00, 4'd1,  0, ST_OK,     4'd0, 5'd0);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[r]) begin
      @(negedge clk);
      push_req(plan[r].req, plan[r].pinned, plan[r].want, calm_spell ? 0 : pick_gap());
    end
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      @(negedge clk);
      q = roll_request();
      push_req(q, 1'b0, '0, calm_spell ? 0 : pick_gap());
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
    pin_on      = 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_cnt == 0 && expected_replies.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    int unsigned idle_left;
    bit          held;
    idle_left    = 0;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held         = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (idle_left != 0) begin
        out_ch.ready = 1'b0;
        idle_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (!calm_spell && $urandom_range(0, 4) == 0) idle_left = pick_gap();
      end
    end
  end

  // beat monitor: score results, predict accepted requests, watch for hangs
  always @(posedge clk) begin
    region_req_t  seen_req;
    region_resp_t got, want, pred;
    bit           moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        results_seen++;
        got = {out_ch.status, out_ch.slot_out, out_ch.region_count};
        if (expected_replies.size() == 0) begin
          $error("result beat with no request outstanding: status %0d slot %0d count %0d",
                 got.status, got.slot_out, got.region_count);
          fault_cnt++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            fault_cnt++;
          end
          if (got.slot_out !== want.slot_out) begin
            $error("slot_out mismatch: expected %0d, got %0d", want.slot_out, got.slot_out);
            fault_cnt++;
          end
          if (got.region_count !== want.region_count) begin
            $error("region_count mismatch: expected %0d, got %0d",
                   want.region_count, got.region_count);
            fault_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved    = 1'b1;
        seen_req = {in_ch.kind, in_ch.address, in_ch.length, in_ch.perm_mask, in_ch.slot};
        pred     = predict_region_op(seen_req);
        // directed rows with a typed result are held to that value
        expected_replies.push_back(pin_on ? pin_resp : pred);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
hw/rtl/srt_pkg.sv
hw/rtl/srt_if.sv
hw/rtl/srt_alu.sv
hw/rtl/srt_mem.sv
hw/rtl/sorted_region_table_checker_unit.sv
sim/tb_top.sv
